[sv/assert_macros.svh]
// assertion macros for the rtl of the spectrum average and peak hold unit
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge out of reset
`define AST_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[sv/sapk_pkg.sv]
// types, constants and tables of the spectrum average and peak hold unit
// no dependencies; used by every module of the block but sapk_div

package sapk_pkg;

	localparam int LVL_W      = 16;
	localparam int BIN_MAX_W  = 13;
	localparam int SLOT_MAX_W = 5;
	localparam int CNT_W      = 4;

	localparam logic signed [15:0] DB10_Q6   = 16'sd640;
	localparam logic signed [15:0] FLOOR_RST = -16'sd7680;
	localparam logic signed [15:0] TOP_RST   = 16'sd768;
	localparam logic [3:0]         AVG_RST   = 4'd1;
	localparam logic [14:0]        DECAY_RST = 15'd100;
	localparam logic [3:0]         BINS_RST  = 4'd10;

	typedef enum logic [2:0] {
		REG_FLOOR = 3'd0,
		REG_TOP   = 3'd1,
		REG_AVG   = 3'd2,
		REG_DECAY = 3'd3,
		REG_BINS  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] floor_db;
		logic signed [15:0] top_db;
		logic [3:0]         avg_frames;
		logic [14:0]        decay_per_frame;
		logic [3:0]         bins_log2;
	} cfg_t;

	// one classified bin handed from front to back
	typedef struct packed {
		logic signed [LVL_W-1:0] level;
		logic [BIN_MAX_W-1:0]    bin;
		logic [SLOT_MAX_W-1:0]   slot;
		logic [CNT_W-1:0]        n;
		logic                    last;
	} cmd_t;

	// floor(2^20 / n), quotient of the bin mean then off by at most one
	function automatic logic [20:0] recip(input logic [3:0] n);
		logic [20:0] r;
		case (n)
			4'd1:    r = 21'd1048576;
			4'd2:    r = 21'd524288;
			4'd3:    r = 21'd349525;
			4'd4:    r = 21'd262144;
			4'd5:    r = 21'd209715;
			4'd6:    r = 21'd174762;
			4'd7:    r = 21'd149796;
			4'd8:    r = 21'd131072;
			4'd9:    r = 21'd116508;
			4'd10:   r = 21'd104857;
			4'd11:   r = 21'd95325;
			4'd12:   r = 21'd87381;
			4'd13:   r = 21'd80659;
			4'd14:   r = 21'd74898;
			4'd15:   r = 21'd69905;
			default: r = 21'd0;
		endcase
		return r;
	endfunction

endpackage

[sv/sapk_queue.sv]
// two-entry queue of classified bins between front and back
// depends on sapk_pkg

module sapk_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sapk_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output sapk_pkg::cmd_t dout,
	output logic           avail,
	output logic [1:0]     count
);

	sapk_pkg::cmd_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign full  = cnt_q == 2'd2;
	assign avail = cnt_q != 2'd0;
	assign dout  = mem_q[rd_q];
	assign count = cnt_q;

endmodule

[sv/sapk_div.sv]
// display range mapper: (v - floor) * 4096 / (top - floor), floored, saturated to 16 bits
// restoring divider, one quotient bit a cycle; no dependencies

module sapk_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] value,
	input  logic signed [15:0] floor_db,
	input  logic signed [15:0] top_db,
	output logic               done,
	output logic signed [15:0] result
);

	localparam int QW = 17;

	logic signed [16:0] diff;
	logic signed [29:0] num;
	logic signed [17:0] den;
	logic signed [29:0] num_a;
	logic signed [17:0] den_a;
	logic [28:0]        mag_n;
	logic [16:0]        mag_d;
	logic [18:0]        trial;
	logic [17:0]        m;

	logic [16:0] rem_q;
	logic [16:0] nsh_q;
	logic [16:0] d_q;
	logic [16:0] q_q;
	logic        neg_q;
	logic        ovf_q;
	logic        zero_q;
	logic [4:0]  cnt_q;

	always_comb begin
		diff  = 17'(value) - 17'(floor_db);
		num   = {{1{diff[16]}}, diff, 12'd0};
		den   = 18'(top_db) - 18'(floor_db);
		num_a = den[17] ? -num : num;
		den_a = den[17] ? -den : den;
		mag_n = num_a[29] ? 29'(-num_a) : num_a[28:0];
		mag_d = den_a[16:0];
		trial = {1'b0, rem_q, nsh_q[16]};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {5'd0, mag_n[28:17]};
			nsh_q  <= mag_n[16:0];
			d_q    <= mag_d;
			q_q    <= '0;
			neg_q  <= num_a[29];
			ovf_q  <= {5'd0, mag_n} >= {mag_d, 17'd0};
			zero_q <= den == 18'sd0;
		end else if (cnt_q != 5'd0) begin
			if (trial >= {2'b0, d_q}) begin
				rem_q <= 17'(trial - {2'b0, d_q});
				q_q   <= {q_q[15:0], 1'b1};
			end else begin
				rem_q <= trial[16:0];
				q_q   <= {q_q[15:0], 1'b0};
			end
			nsh_q <= {nsh_q[15:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'(QW);
		end else if (cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	assign done = cnt_q == 5'd0;

	// negative quotients round down: magnitude grows by one on a remainder
	always_comb begin
		m = {1'b0, q_q} + 18'(rem_q != 17'd0);
		if (zero_q) begin
			result = '0;
		end else if (ovf_q) begin
			result = neg_q ? -16'sd32768 : 16'sd32767;
		end else if (!neg_q) begin
			result = (q_q > 17'd32767) ? 16'sd32767 : signed'(q_q[15:0]);
		end else begin
			result = (m > 18'd32768) ? -16'sd32768 : signed'(16'(18'd0 - m));
		end
	end

endmodule

[sv/sapk_front.sv]
// front end: takes bin beats, tracks bin, history slot and frame count, queues work
// depends on sapk_pkg

module sapk_front #(
	parameter int MAX_BINS  = 8192,
	parameter int AVG_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sapk_pkg::cfg_t    cfg,
	input  logic              enable,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // level_db
	input  logic              s_tlast,   // end_of_frame
	input  logic              q_full,
	output logic              push,
	output sapk_pkg::cmd_t    cmd
);

	localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

	logic [BIN_W-1:0]  bin_q;
	logic [SLOT_W-1:0] slot_q;
	logic [3:0]        seen_q;
	logic [3:0]        lim;
	logic [4:0]        nxt;
	logic [3:0]        n;

	always_comb begin
		if (cfg.avg_frames == 4'd0) begin
			lim = 4'd1;
		end else if ({2'b0, cfg.avg_frames} > 6'(AVG_DEPTH)) begin
			lim = 4'(AVG_DEPTH);
		end else begin
			lim = cfg.avg_frames;
		end
		nxt = {1'b0, seen_q} + 5'd1;
		n   = (nxt > {1'b0, lim}) ? lim : nxt[3:0];
	end

	assign s_tready = enable && !q_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		cmd.level = signed'(s_tdata);
		cmd.bin   = sapk_pkg::BIN_MAX_W'(bin_q);
		cmd.slot  = sapk_pkg::SLOT_MAX_W'(slot_q);
		cmd.n     = n;
		cmd.last  = s_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q  <= '0;
			slot_q <= '0;
			seen_q <= '0;
		end else if (push) begin
			if (s_tlast) begin
				bin_q  <= '0;
				seen_q <= n;
				slot_q <= (slot_q == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end else begin
				bin_q <= (bin_q == BIN_W'(MAX_BINS - 1)) ? '0 : bin_q + 1'b1;
			end
		end
	end

endmodule

[sv/sapk_back.sv]
// back end: history and peak memories, per-bin mean and peak, frame figures, result register
// depends on sapk_pkg and sapk_div

module sapk_back #(
	parameter int MAX_BINS  = 8192,
	parameter int AVG_DEPTH = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sapk_pkg::cfg_t cfg,
	input  logic           q_avail,
	output logic           q_pop,
	input  sapk_pkg::cmd_t cmd,
	output logic           clear_done,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [63:0]    m_tdata,   // avg_norm, peak_norm, frame_peak_db, frame_mean_db
	output logic           m_tlast    // last_out
);

	localparam int BIN_W      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int SLOT_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int HIST_DEPTH = AVG_DEPTH * MAX_BINS;
	localparam int HA         = $clog2(HIST_DEPTH);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_RD    = 8'b0000_0100,
		S_MEAN1 = 8'b0000_1000,
		S_MEAN2 = 8'b0001_0000,
		S_PEAK  = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	logic signed [15:0] hist_mem [HIST_DEPTH];
	logic signed [15:0] peak_mem [MAX_BINS];

	state_t              state_q;
	logic [HA-1:0]       clr_q;
	sapk_pkg::cmd_t      cur_q;
	logic [3:0]          k_q;
	logic [SLOT_W-1:0]   rs_q;
	logic                pend_q;
	logic signed [19:0]  sum_q;
	logic [19:0]         u_q;
	logic [40:0]         prod_q;
	logic signed [15:0]  mean_q;
	logic signed [15:0]  rp_q;
	logic [31:0]         acc_q;
	logic signed [15:0]  fpk_q;
	logic signed [33:0]  total_q;
	logic signed [15:0]  h_rdata_q;
	logic signed [15:0]  p_rdata_q;
	logic                m_tvalid_q;
	logic [63:0]         m_tdata_q;
	logic                m_tlast_q;

	logic               h_we, h_re, p_we, p_re;
	logic [HA-1:0]      h_waddr, h_raddr;
	logic [BIN_W-1:0]   p_waddr, p_raddr;
	logic signed [15:0] h_wdata, p_wdata;

	logic [BIN_W-1:0]   cur_bin;
	logic [SLOT_W-1:0]  cur_slot;
	logic               issue;
	logic [19:0]        u;
	logic [15:0]        q_est;
	logic [19:0]        rem;
	logic [15:0]        q_fix;
	logic signed [16:0] dec;
	logic signed [15:0] pk;
	logic signed [15:0] rp_new;
	logic [31:0]        acc_new;
	logic signed [33:0] fm_shift;
	logic signed [15:0] fm;
	logic               div_start;
	logic               avg_done, pk_done;
	logic signed [15:0] avg_norm, peak_norm;
	logic               out_free;

	function automatic logic [HA-1:0] haddr(input logic [SLOT_W-1:0] s,
		input logic [BIN_W-1:0] b);
		return HA'(int'(s) * MAX_BINS + int'(b));
	endfunction

	function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
		return (s == '0) ? SLOT_W'(AVG_DEPTH - 1) : s - 1'b1;
	endfunction

	assign cur_bin  = cur_q.bin[BIN_W-1:0];
	assign cur_slot = cur_q.slot[SLOT_W-1:0];
	assign issue    = k_q != cur_q.n;
	assign out_free = !m_tvalid_q || m_tready;

	// mean arithmetic: bias by 32768 per frame so the reciprocal works on a non-negative sum
	always_comb begin
		u     = 20'(sum_q) + 20'({cur_q.n, 15'd0});
		q_est = prod_q[35:20];
		rem   = u_q - 20'(q_est) * 20'(cur_q.n);
		q_fix = (rem >= 20'(cur_q.n)) ? q_est + 16'd1 : q_est;
	end

	always_comb begin
		dec = 17'(p_rdata_q) - signed'({2'b0, cfg.decay_per_frame});
		if (mean_q > p_rdata_q) begin
			pk = mean_q;
		end else if (dec < 17'(cfg.floor_db)) begin
			pk = cfg.floor_db;
		end else begin
			pk = dec[15:0];
		end
		rp_new  = (pk > rp_q) ? pk : rp_q;
		acc_new = acc_q + 32'(mean_q);
	end

	always_comb begin
		fm_shift = total_q >>> cfg.bins_log2;
		if (fm_shift > 34'sd32767) begin
			fm = 16'sd32767;
		end else if (fm_shift < -34'sd32768) begin
			fm = -16'sd32768;
		end else begin
			fm = fm_shift[15:0];
		end
	end

	// memory port control
	always_comb begin
		h_we    = 1'b0;
		h_waddr = haddr(SLOT_W'(cmd.slot), BIN_W'(cmd.bin));
		h_wdata = cmd.level;
		h_re    = 1'b0;
		h_raddr = haddr(rs_q, cur_bin);
		p_we    = 1'b0;
		p_waddr = cur_bin;
		p_wdata = pk;
		p_re    = 1'b0;
		p_raddr = BIN_W'(cmd.bin);
		q_pop   = 1'b0;
		div_start = 1'b0;
		case (state_q)
			S_CLEAR: begin
				h_we    = 1'b1;
				h_waddr = clr_q;
				h_wdata = sapk_pkg::FLOOR_RST;
				p_we    = int'(clr_q) < MAX_BINS;
				p_waddr = BIN_W'(clr_q);
				p_wdata = sapk_pkg::FLOOR_RST;
			end
			S_IDLE: begin
				q_pop = q_avail;
				h_we  = q_avail;
				p_re  = q_avail;
			end
			S_RD: begin
				h_re = issue;
			end
			S_PEAK: begin
				p_we      = 1'b1;
				div_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			hist_mem[h_waddr] <= h_wdata;
		end
		if (h_re) begin
			h_rdata_q <= hist_mem[h_raddr];
		end
		if (p_we) begin
			peak_mem[p_waddr] <= p_wdata;
		end
		if (p_re) begin
			p_rdata_q <= peak_mem[p_raddr];
		end
	end

	// per-item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_avail) begin
					cur_q <= cmd;
					sum_q <= 20'(cmd.level);
					k_q   <= 4'd1;
					rs_q  <= slot_dec(SLOT_W'(cmd.slot));
				end
			end
			S_RD: begin
				if (issue) begin
					k_q  <= k_q + 4'd1;
					rs_q <= slot_dec(rs_q);
				end
				if (pend_q) begin
					sum_q <= sum_q + 20'(h_rdata_q);
				end
			end
			S_MEAN1: begin
				u_q    <= u;
				prod_q <= 41'(u) * 41'(sapk_pkg::recip(cur_q.n));
			end
			S_MEAN2: begin
				mean_q <= signed'({~q_fix[15], q_fix[14:0]});
			end
			S_PEAK: begin
				fpk_q   <= rp_new;
				total_q <= 34'(rp_new) - 34'(sapk_pkg::DB10_Q6) + 34'(signed'(acc_new));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
			rp_q    <= sapk_pkg::FLOOR_RST;
			acc_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == HA'(HIST_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					pend_q <= 1'b0;
					if (q_avail) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					pend_q <= issue;
					if (!issue && !pend_q) begin
						state_q <= S_MEAN1;
					end
				end
				S_MEAN1: state_q <= S_MEAN2;
				S_MEAN2: state_q <= S_PEAK;
				S_PEAK: begin
					if (cur_q.last) begin
						rp_q  <= cfg.floor_db;
						acc_q <= '0;
					end else begin
						rp_q  <= rp_new;
						acc_q <= acc_new;
					end
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (avg_done && pk_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	sapk_div u_avg_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.value    (mean_q),
		.floor_db (cfg.floor_db),
		.top_db   (cfg.top_db),
		.done     (avg_done),
		.result   (avg_norm)
	);

	sapk_div u_pk_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.value    (pk),
		.floor_db (cfg.floor_db),
		.top_db   (cfg.top_db),
		.done     (pk_done),
		.result   (peak_norm)
	);

	// result register, frame figures only on the closing beat
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			m_tdata_q[15:0]  <= avg_norm;
			m_tdata_q[31:16] <= peak_norm;
			m_tdata_q[47:32] <= cur_q.last ? fpk_q : 16'd0;
			m_tdata_q[63:48] <= cur_q.last ? fm : 16'd0;
			m_tlast_q        <= cur_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tlast    = m_tlast_q;
	assign clear_done = state_q != S_CLEAR;

endmodule

[sv/spectrum_average_peak_hold_unit.sv]
// Spectrum average and peak hold unit: one Q9.6 dB bin level a beat, bins of a frame in
// order, tlast on the last bin. Each beat gives one result beat: the bin mean over the
// last avg_frames frames and the held peak, both mapped to [floor_db, top_db] as Q3.12,
// plus frame peak and frame mean on the closing beat. After reset the history and peak
// memories are swept to -120 dB (AVG_DEPTH * MAX_BINS history entries, 65536 by default) while
// s_tready stays low; registers can be written meanwhile. Items are worked one at a time,
// each through the serial history reads of the n frames averaged and the 17-step
// dividers of the display mapping. A two-entry queue and the result register let input
// and output stall independently.
// depends on sapk_pkg, sapk_queue, sapk_front, sapk_back and assert_macros.svh
`include "assert_macros.svh"

module spectrum_average_peak_hold_unit #(
	parameter int MAX_BINS  = 8192,
	parameter int AVG_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // level_db
	input  logic        s_tlast,   // end_of_frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // avg_norm, peak_norm, frame_peak_db, frame_mean_db
	output logic        m_tlast    // last_out
);

	sapk_pkg::cfg_t     cfg_q;
	sapk_pkg::reg_idx_t idx;
	logic               wr_en;
	logic               q_full, q_push, q_pop, q_avail;
	logic [1:0]         q_count;
	sapk_pkg::cmd_t     q_din, q_dout;
	logic               clear_done;

	assign pready = 1'b1;
	assign idx    = sapk_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.floor_db        <= sapk_pkg::FLOOR_RST;
			cfg_q.top_db          <= sapk_pkg::TOP_RST;
			cfg_q.avg_frames      <= sapk_pkg::AVG_RST;
			cfg_q.decay_per_frame <= sapk_pkg::DECAY_RST;
			cfg_q.bins_log2       <= sapk_pkg::BINS_RST;
		end else if (wr_en) begin
			case (idx)
				sapk_pkg::REG_FLOOR: cfg_q.floor_db        <= pwdata[15:0];
				sapk_pkg::REG_TOP:   cfg_q.top_db          <= pwdata[15:0];
				sapk_pkg::REG_AVG:   cfg_q.avg_frames      <= pwdata[3:0];
				sapk_pkg::REG_DECAY: cfg_q.decay_per_frame <= pwdata[14:0];
				sapk_pkg::REG_BINS:  cfg_q.bins_log2       <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			sapk_pkg::REG_FLOOR: prdata = 32'(cfg_q.floor_db);
			sapk_pkg::REG_TOP:   prdata = 32'(cfg_q.top_db);
			sapk_pkg::REG_AVG:   prdata = {28'd0, cfg_q.avg_frames};
			sapk_pkg::REG_DECAY: prdata = {17'd0, cfg_q.decay_per_frame};
			sapk_pkg::REG_BINS:  prdata = {28'd0, cfg_q.bins_log2};
			default:             prdata = '0;
		endcase
	end

	sapk_front #(
		.MAX_BINS  (MAX_BINS),
		.AVG_DEPTH (AVG_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.enable   (clear_done),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (q_push),
		.cmd      (q_din)
	);

	sapk_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.avail  (q_avail),
		.count  (q_count)
	);

	sapk_back #(
		.MAX_BINS  (MAX_BINS),
		.AVG_DEPTH (AVG_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_avail    (q_avail),
		.q_pop      (q_pop),
		.cmd        (q_dout),
		.clear_done (clear_done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

	`AST_IMPLY(a_no_input_while_clearing, clk, arst_n, !clear_done, !s_tready && !q_avail, "input taken during memory sweep")
	`AST_ALWAYS(a_queue_bound, clk, arst_n, q_count != 2'd3, "queue count beyond depth")
	`AST_IMPLY(a_frame_fields_zero, clk, arst_n, m_tvalid && !m_tlast, m_tdata[63:32] == 32'd0, "frame figures on a non-closing beat")

endmodule

[dv/tb_spectrum_average_peak_hold_unit.sv]
// testbench of the spectrum average and peak hold unit: stream driver, checker, register writes
// predicts every result beat from its own copy of the history, peak and frame state
// depends on sapk_pkg and spectrum_average_peak_hold_unit
`timescale 1ns / 100ps

module tb_spectrum_average_peak_hold_unit;

	localparam int BINS  = 8192;
	localparam int DEPTH = 8;

	typedef struct {
		logic signed [15:0] level;
		logic               eof;
	} bin_in_t;

	typedef struct packed {
		logic signed [15:0] avg_norm;
		logic signed [15:0] peak_norm;
		logic signed [15:0] fpeak;
		logic signed [15:0] fmean;
		logic               last;
	} bin_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // level_db
	logic        s_tlast = 1'b0; // end_of_frame
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // avg_norm, peak_norm, frame_peak_db, frame_mean_db
	logic        m_tlast;        // last_out

	spectrum_average_peak_hold_unit u_top (.*);

	always #10 clk = ~clk;

	// local copy of the block state
	int              hist [DEPTH][BINS];
	int              peaks [BINS];
	int              bin_pos, slot_pos, frames_seen, run_peak;
	logic [31:0]     mean_acc;
	sapk_pkg::cfg_t  cfg;

	bin_in_t  pending_bins [$];
	bin_res_t expected_res [$];
	int       mismatches = 0;
	int       beats_in = 0, beats_out = 0;
	bit       quiet = 0;

	function automatic longint div_floor(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && ((a < 0) != (b < 0)))
			q--;
		return q;
	endfunction

	function automatic longint sat16(longint v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	function automatic logic [15:0] to_display(longint v);
		longint num, den;
		num = (v - cfg.floor_db) * 4096;
		den = longint'(cfg.top_db) - cfg.floor_db;
		if (den == 0)
			return '0;
		return 16'(sat16(div_floor(num, den)));
	endfunction

	task automatic predict_bin(bin_in_t b);
		int       lim, n, s;
		longint   sum, mean, pk, total;
		bin_res_t r;
		lim = cfg.avg_frames;
		if (lim < 1) lim = 1;
		if (lim > DEPTH) lim = DEPTH;
		n = frames_seen + 1;
		if (n > lim) n = lim;
		hist[slot_pos][bin_pos] = b.level;
		sum = 0;
		for (int k = 0; k < n; k++) begin
			s = (slot_pos + DEPTH - k) % DEPTH;
			sum += hist[s][bin_pos];
		end
		mean = sat16(div_floor(sum, n));
		pk = peaks[bin_pos];
		if (mean > pk) begin
			pk = mean;
		end else begin
			pk -= cfg.decay_per_frame;
			if (pk < cfg.floor_db) pk = cfg.floor_db;
		end
		peaks[bin_pos] = int'(pk);
		if (pk > run_peak) run_peak = int'(pk);
		mean_acc += 32'(mean);
		r.avg_norm = to_display(mean);
		r.peak_norm = to_display(pk);
		r.fpeak = '0;
		r.fmean = '0;
		r.last = b.eof;
		if (b.eof) begin
			total = longint'(run_peak) - 640 + longint'($signed(mean_acc));
			r.fpeak = 16'(sat16(run_peak));
			r.fmean = 16'(sat16(div_floor(total, longint'(1) << cfg.bins_log2)));
			frames_seen = n;
			slot_pos = (slot_pos + 1) % DEPTH;
			bin_pos = 0;
			run_peak = cfg.floor_db;
			mean_acc = '0;
		end else begin
			bin_pos = (bin_pos + 1) % BINS;
		end
		expected_res.push_back(r);
	endtask

	// sender: one beat held until accepted, random gaps between beats
	int send_gap = 0;
	always @(posedge clk) begin
		bit held;
		held = s_tvalid && !s_tready;
		if (s_tvalid && s_tready) begin
			predict_bin(pending_bins.pop_front());
			beats_in++;
		end
		if (!held) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_bins.size() != 0 && !quiet && $urandom_range(0, 6) == 0) begin
				send_gap <= $urandom_range(0, 4);
				s_tvalid <= 1'b0;
			end else if (pending_bins.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_bins[0].level;
				s_tlast <= pending_bins[0].eof;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: checks each beat, random stalls and one long hold-off
	int  stall_left = 0;
	bit  long_done = 0;
	always @(posedge clk) begin
		bin_res_t e, got;
		if (m_tvalid && m_tready) begin
			beats_out++;
			got.avg_norm = m_tdata[15:0];
			got.peak_norm = m_tdata[31:16];
			got.fpeak = m_tdata[47:32];
			got.fmean = m_tdata[63:48];
			got.last = m_tlast;
			if (expected_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h last %b", m_tdata, m_tlast);
			end else begin
				e = expected_res.pop_front();
				if (got != e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d exp %0d %0d %0d %0d %b got %0d %0d %0d %0d %b",
							beats_out, e.avg_norm, e.peak_norm, e.fpeak, e.fmean, e.last,
							got.avg_norm, got.peak_norm, got.fpeak, got.fmean, got.last);
				end
			end
		end
		if (!long_done && beats_in >= 400) begin
			long_done <= 1;
			stall_left <= 200;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 6) == 0) begin
			stall_left <= $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic reg_write(sapk_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			sapk_pkg::REG_FLOOR: cfg.floor_db = val[15:0];
			sapk_pkg::REG_TOP:   cfg.top_db = val[15:0];
			sapk_pkg::REG_AVG:   cfg.avg_frames = val[3:0];
			sapk_pkg::REG_DECAY: cfg.decay_per_frame = val[14:0];
			sapk_pkg::REG_BINS:  cfg.bins_log2 = val[3:0];
			default: ;
		endcase
	endtask

	task automatic push_bin(int lvl, bit eof);
		bin_in_t b;
		b.level = 16'(lvl);
		b.eof = eof;
		pending_bins.push_back(b);
	endtask

	// random frames, short ones so that the history wraps often
	task automatic push_frames(int count);
		int len, lvl;
		for (int i = 0; i < count; i += len) begin
			len = $urandom_range(1, 10);
			for (int j = 0; j < len; j++) begin
				case ($urandom_range(0, 5))
					0:       lvl = $urandom_range(0, 65535) - 32768;
					1:       lvl = $urandom_range(0, 1) ? 32767 : -32768;
					default: lvl = int'(cfg.floor_db) + $urandom_range(0, 10000) - 1500;
				endcase
				push_bin(lvl, (j == len - 1) && ($urandom_range(0, 15) != 0));
			end
		end
	endtask

	task automatic drain;
		while (pending_bins.size() != 0 || s_tvalid || expected_res.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		cfg.floor_db = sapk_pkg::FLOOR_RST;
		cfg.top_db = sapk_pkg::TOP_RST;
		cfg.avg_frames = sapk_pkg::AVG_RST;
		cfg.decay_per_frame = sapk_pkg::DECAY_RST;
		cfg.bins_log2 = sapk_pkg::BINS_RST;
		foreach (hist[s, b]) hist[s][b] = -7680;
		foreach (peaks[b]) peaks[b] = -7680;
		bin_pos = 0; slot_pos = 0; frames_seen = 0; run_peak = -7680; mean_acc = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: level extremes, single-bin frames, peak decay at reset settings
		push_bin(32767, 0); push_bin(-32768, 0); push_bin(0, 0); push_bin(-7680, 0);
		push_bin(768, 1);
		push_bin(-32768, 1); push_bin(32767, 1); push_bin(-1, 0); push_bin(-7681, 1);
		drain();
		reg_write(sapk_pkg::REG_AVG, 8);
		reg_write(sapk_pkg::REG_DECAY, 0);
		for (int f = 0; f < 10; f++) begin
			push_bin(32767 - f * 7000, 0);
			push_bin(-32768 + f * 3, 1);
		end
		drain();
		reg_write(sapk_pkg::REG_AVG, 0);          // acts as one
		reg_write(sapk_pkg::REG_DECAY, 32767);
		reg_write(sapk_pkg::REG_BINS, 0);
		push_frames(150);
		drain();
		reg_write(sapk_pkg::REG_AVG, 15);         // clamps to full depth
		reg_write(sapk_pkg::REG_BINS, 15);
		reg_write(sapk_pkg::REG_FLOOR, 32'hFFFF_8000);
		reg_write(sapk_pkg::REG_TOP, 32'h0000_7FFF);
		reg_write(sapk_pkg::REG_DECAY, 1);
		push_frames(250);
		drain();
		// empty display range
		reg_write(sapk_pkg::REG_FLOOR, 32'h0000_0100);
		reg_write(sapk_pkg::REG_TOP, 32'h0000_0100);
		reg_write(sapk_pkg::REG_AVG, 3);
		push_frames(150);
		drain();
		// inverted display range
		reg_write(sapk_pkg::REG_FLOOR, 32'h0000_0300);
		reg_write(sapk_pkg::REG_TOP, 32'hFFFF_E200);
		reg_write(sapk_pkg::REG_BINS, 13);
		reg_write(sapk_pkg::REG_DECAY, 500);
		push_frames(250);
		drain();
		reg_write(sapk_pkg::REG_FLOOR, 32'hFFFF_E200);
		reg_write(sapk_pkg::REG_TOP, 32'h0000_0300);
		reg_write(sapk_pkg::REG_AVG, 5);
		reg_write(sapk_pkg::REG_BINS, 10);
		reg_write(sapk_pkg::REG_DECAY, 100);
		push_frames(350);
		drain();
		reg_write(sapk_pkg::REG_AVG, 8);
		reg_write(sapk_pkg::REG_DECAY, 40);
		reg_write(sapk_pkg::REG_BINS, 12);
		push_frames(350);
		drain();
		quiet = 1;
		reg_write(sapk_pkg::REG_AVG, 2);
		push_frames(250);
		drain();
		if (mismatches == 0 && expected_res.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
